// ===== rtl/aktt_pkg.sv =====
// Shared types, widths and operation codes of the aging key timer table.
package aktt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int KEY_BITS_DEF      = 32;

    localparam int OP_W       = 2;
    localparam int KEY_IN_W   = 32;
    localparam int KEY_WIDE_W = 64;
    localparam int DUR_W      = 15;
    localparam int TIMER_W    = 16;

    localparam logic [OP_W-1:0] OP_TAG   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [KEY_IN_W-1:0] key;
        logic [DUR_W-1:0]    duration;
        logic                key_alive;
    } in_word_t;

    typedef struct packed {
        logic present;
        logic stored;
    } out_word_t;

endpackage

// ===== rtl/aktt_mem.sv =====
// Entry store: key and timer per slot, registered read, per-slot valid bits.
module aktt_mem #(
    parameter int TABLE_ENTRIES = aktt_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = aktt_pkg::KEY_BITS_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int ENT_W        = KEY_BITS + aktt_pkg::TIMER_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [KEY_BITS-1:0]          rd_key,
    output logic [aktt_pkg::TIMER_W-1:0] rd_timer,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [KEY_BITS-1:0]          wr_key,
    input  logic [aktt_pkg::TIMER_W-1:0] wr_timer
);

    logic [ENT_W-1:0]         mem_q [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] vld_reg;
    logic [ENT_W-1:0]         rd_data_reg;
    logic                     rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= {wr_key, wr_timer};
        end
        if (rd_en) begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    // a slot never written reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_key   = rd_vld_reg ? rd_data_reg[ENT_W-1 -: KEY_BITS] : '0;
    assign rd_timer = rd_vld_reg ? rd_data_reg[aktt_pkg::TIMER_W-1:0] : '0;

endmodule

// ===== rtl/aktt_seq.sv =====
// Sequencer: walks the entry store at most once per operation, read-modify-write.
module aktt_seq #(
    parameter int TABLE_ENTRIES = aktt_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = aktt_pkg::KEY_BITS_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  aktt_pkg::in_word_t           s_word,
    output logic                         res_valid,
    input  logic                         res_ready,
    output aktt_pkg::out_word_t          res_word,
    output logic                         rd_en,
    output logic [IDX_W-1:0]             rd_addr,
    input  logic [KEY_BITS-1:0]          rd_key,
    input  logic [aktt_pkg::TIMER_W-1:0] rd_timer,
    output logic                         wr_en,
    output logic [IDX_W-1:0]             wr_addr,
    output logic [KEY_BITS-1:0]          wr_key,
    output logic [aktt_pkg::TIMER_W-1:0] wr_timer
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [1:0]                   state_reg, state_next;
    logic [aktt_pkg::OP_W-1:0]    op_reg, op_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [aktt_pkg::DUR_W-1:0]   dur_reg, dur_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic                         free_found_reg, free_found_next;
    logic                         present_reg, present_next;
    logic                         stored_reg, stored_next;

    logic [aktt_pkg::KEY_WIDE_W-1:0] key_wide;
    logic [KEY_BITS-1:0]             key_m;
    logic                            last;
    logic                            trivial;
    logic [aktt_pkg::TIMER_W-1:0]    dur_ext;

    assign key_wide = aktt_pkg::KEY_WIDE_W'(s_word.key);
    assign key_m    = key_wide[KEY_BITS-1:0];
    assign last     = (idx_reg == LAST_IDX);
    assign dur_ext  = aktt_pkg::TIMER_W'(dur_reg);

    // ops that finish without touching the table
    always_comb begin
        case (s_word.op)
            aktt_pkg::OP_TAG:   trivial = (key_m == '0) || !s_word.key_alive;
            aktt_pkg::OP_QUERY: trivial = (key_m == '0);
            aktt_pkg::OP_TICK:  trivial = 1'b0;
            default:            trivial = 1'b1;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        dur_next        = dur_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        present_next    = present_reg;
        stored_next     = stored_reg;
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg + 1'b1;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_key          = rd_key;
        wr_timer        = rd_timer;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next         = s_word.op;
                    key_next        = key_m;
                    dur_next        = s_word.duration;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    present_next    = 1'b0;
                    stored_next     = 1'b0;
                    if (trivial) begin
                        state_next = ST_FINISH;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en    = !last;
                idx_next = idx_reg + 1'b1;
                if (last) begin
                    state_next = ST_FINISH;
                end
                case (op_reg)
                    aktt_pkg::OP_TICK: begin
                        if (rd_key != '0) begin
                            wr_en = 1'b1;
                            if (rd_timer <= aktt_pkg::TIMER_W'(1)) begin
                                wr_key   = '0;
                                wr_timer = '0;
                            end else begin
                                wr_timer = rd_timer - 1'b1;
                            end
                        end
                    end
                    aktt_pkg::OP_QUERY: begin
                        if (rd_key == key_reg && rd_timer != '0) begin
                            present_next = 1'b1;
                            state_next   = ST_FINISH;
                        end
                    end
                    aktt_pkg::OP_TAG: begin
                        if (rd_key == key_reg) begin
                            stored_next = 1'b1;
                            state_next  = ST_FINISH;
                            if (dur_ext > rd_timer) begin
                                wr_en    = 1'b1;
                                wr_timer = dur_ext;
                            end
                        end else begin
                            if (rd_key == '0 && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            // no match anywhere: insert at lowest empty slot
                            if (last && (free_found_reg || rd_key == '0)) begin
                                wr_en       = 1'b1;
                                wr_addr     = free_found_reg ? free_idx_reg : idx_reg;
                                wr_key      = key_reg;
                                wr_timer    = dur_ext;
                                stored_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_word.present = present_reg;
    assign res_word.stored  = stored_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        dur_reg        <= dur_next;
        idx_reg        <= idx_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        present_reg    <= present_next;
        stored_reg     <= stored_next;
    end

    a_no_rw_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same entry");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res_word.present && res_word.stored))
        else $error("present and stored both set");

    a_present_only_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && op_reg != aktt_pkg::OP_QUERY) |-> !res_word.present)
        else $error("present set for a non-query word");

    a_stored_only_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && op_reg != aktt_pkg::OP_TAG) |-> !res_word.stored)
        else $error("stored set for a non-tag word");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while one is in flight");

endmodule

// ===== rtl/aging_key_timer_table.sv =====
// Top level of the aging key timer table: sequencer, entry store, output register.
//
// Usage:
//   s_valid/s_ready/s_word carry one operation word: tag (op 0), query (op 1)
//   or tick (op 2). Every accepted word gives exactly one result word on
//   m_valid/m_ready/m_word (present for a query, stored for a tag).
//   Words that need no table access (tag of key 0 or of a dead key, query of
//   key 0, op 3) skip the table walk and go straight to the result. A query
//   or tag ends early on a hit; a tick, a tag that inserts or is dropped and
//   a missed query walk all TABLE_ENTRIES slots.
//   Throughput: one operation at a time; the sequencer reads one slot, and
//   writes it back if needed, per cycle. The result sits in an output
//   register, so the next word is accepted while an earlier result still
//   waits on m_ready; a stalled receiver only holds up the sequencer when a
//   second result is ready to hand over.
//   Reset (aresetn low, synchronous) empties the table at once through
//   per-slot valid bits; no clearing pass is needed.
module aging_key_timer_table #(
    parameter int TABLE_ENTRIES = aktt_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = aktt_pkg::KEY_BITS_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aktt_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output aktt_pkg::out_word_t m_word
);

    // sequencer <-> entry store
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [KEY_BITS-1:0]          rd_key;
    logic [aktt_pkg::TIMER_W-1:0] rd_timer;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [KEY_BITS-1:0]          wr_key;
    logic [aktt_pkg::TIMER_W-1:0] wr_timer;

    // sequencer -> output register
    logic                res_valid;
    logic                res_ready;
    aktt_pkg::out_word_t res_word;

    logic                m_valid_reg, m_valid_next;
    aktt_pkg::out_word_t m_word_reg, m_word_next;

    aktt_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BITS     (KEY_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_word (res_word),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_timer (rd_timer),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_timer (wr_timer)
    );

    aktt_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BITS     (KEY_BITS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_timer(rd_timer),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_timer(wr_timer)
    );

    // output register takes a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_word_next = res_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    a_no_result_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && res_valid) |=> res_valid)
        else $error("finished result dropped while output is stalled");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (m_valid && m_word == $past(res_word)))
        else $error("output register missed a finished result");

    a_busy_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("input accepted while a result is unsent");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the aging key timer table: directed cases, then random traffic.
module testbench;

    // op value 3 has no name in the package; the block must treat it as a no-op
    localparam logic [aktt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int SLOTS       = aktt_pkg::TABLE_ENTRIES_DEF;
    localparam int KEY_POOL_SZ = 40;    // a few more keys than slots, so the table can fill
    // worst case between two handshakes is the long receiver hold-off plus a
    // full table walk and a run of random stalls; take that several times over
    localparam int STALL_LIMIT = 2500;
    localparam int TAIL_CYCLES = SLOTS + 8;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    aktt_pkg::in_word_t  s_word  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    aktt_pkg::out_word_t m_word;

    aging_key_timer_table u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the table, updated in accept order
    // ------------------------------------------------------------------
    logic [aktt_pkg::KEY_IN_W-1:0] slot_key   [SLOTS] = '{default: '0};
    logic [aktt_pkg::TIMER_W-1:0]  slot_timer [SLOTS] = '{default: '0};
    aktt_pkg::out_word_t           pending_results[$];
    logic [aktt_pkg::KEY_IN_W-1:0] key_pool   [KEY_POOL_SZ];

    int error_count    = 0;
    int sender_gap_pct = 0;     // chance per cycle that the sender idles before a word
    int sink_stall_pct = 0;     // chance per cycle that m_ready is low
    int hold_len       = 0;     // long receiver hold-off asked for by a test
    int hold_cycles    = 0;     // cycles of that hold-off still to go, kept by the receiver
    bit hold_started   = 1'b0;
    int quiet_cycles   = 0;

    // Apply one word to the shadow table and return the result it must produce.
    function automatic aktt_pkg::out_word_t table_update(input aktt_pkg::in_word_t w);
        aktt_pkg::out_word_t r;
        int                  hit;
        int                  free_idx;
        r        = '0;
        hit      = -1;
        free_idx = -1;
        case (w.op)
            aktt_pkg::OP_TAG: begin
                // dead objects and key zero are ignored outright
                if (w.key != '0 && w.key_alive) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (hit < 0 && slot_key[i] == w.key) hit = i;
                        if (free_idx < 0 && slot_key[i] == '0) free_idx = i;
                    end
                    if (hit >= 0) begin
                        // refresh only raises the timer; stored either way
                        if ({1'b0, w.duration} > slot_timer[hit])
                            slot_timer[hit] = {1'b0, w.duration};
                        r.stored = 1'b1;
                    end else if (free_idx >= 0) begin
                        slot_key[free_idx]   = w.key;
                        slot_timer[free_idx] = {1'b0, w.duration};
                        r.stored = 1'b1;
                    end
                    // no hit and no free slot: dropped, stored stays 0
                end
            end
            aktt_pkg::OP_QUERY: begin
                if (w.key != '0)
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_key[i] == w.key && slot_timer[i] != '0) r.present = 1'b1;
            end
            aktt_pkg::OP_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_key[i] != '0) begin
                        // timer 0 or 1 expires this frame
                        if (slot_timer[i] <= 1) begin
                            slot_key[i]   = '0;
                            slot_timer[i] = '0;
                        end else begin
                            slot_timer[i] = slot_timer[i] - 1'b1;
                        end
                    end
                end
            end
            default: ;  // unused op: no state change, both flags low
        endcase
        return r;
    endfunction

    function automatic aktt_pkg::in_word_t make_word(
        input logic [aktt_pkg::OP_W-1:0]     op,
        input logic [aktt_pkg::KEY_IN_W-1:0] key,
        input logic [aktt_pkg::DUR_W-1:0]    dur,
        input logic                          alive);
        aktt_pkg::in_word_t w;
        w.op        = op;
        w.key       = key;
        w.duration  = dur;
        w.key_alive = alive;
        return w;
    endfunction

    function automatic logic [aktt_pkg::DUR_W-1:0] any_duration();
        return aktt_pkg::DUR_W'($urandom_range(32767));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(1));
    endfunction

    // Mostly keys from the pool so tags and queries hit; some zero and fresh keys as noise.
    function automatic logic [aktt_pkg::KEY_IN_W-1:0] pick_key();
        int r;
        r = $urandom_range(63);
        if (r == 0) return '0;
        if (r < 4)  return $urandom;
        return key_pool[$urandom_range(KEY_POOL_SZ - 1)];
    endfunction

    // Short durations keep the table churning; rare long ones exercise the upper bits.
    function automatic logic [aktt_pkg::DUR_W-1:0] pick_duration();
        if ($urandom_range(127) == 0) return any_duration();
        return aktt_pkg::DUR_W'($urandom_range(12));
    endfunction

    function automatic aktt_pkg::in_word_t random_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return make_word(aktt_pkg::OP_TAG, pick_key(), pick_duration(),
                             $urandom_range(15) != 0);
        if (sel < 75)
            return make_word(aktt_pkg::OP_QUERY, pick_key(), any_duration(), any_bit());
        if (sel < 95)
            return make_word(aktt_pkg::OP_TICK, $urandom, any_duration(), any_bit());
        return make_word(OP_UNUSED, pick_key(), any_duration(), any_bit());
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle cycles, then hold valid until the word is taken.
    // Valid stays high into the next call, so back-to-back words see no bubble.
    // ------------------------------------------------------------------
    task automatic send_word(input aktt_pkg::in_word_t w);
        while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: a pending long hold-off wins over the random stall pattern
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!hold_started && hold_len > 0) begin
            hold_started <= 1'b1;
            hold_cycles  <= hold_len - 1;
            m_ready      <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input word, check every result word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        aktt_pkg::out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: present=%0b stored=%0b",
                           m_word.present, m_word.stored);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_word.present !== want.present) begin
                        $error("present: expected %0b, got %0b", want.present, m_word.present);
                        error_count++;
                    end
                    if (m_word.stored !== want.stored) begin
                        $error("stored: expected %0b, got %0b", want.stored, m_word.stored);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(table_update(s_word));
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries and tags on key zero, dead tags, refresh that does not raise, op 3.
    task automatic test_basic_ops();
        logic [aktt_pkg::KEY_IN_W-1:0] k;
        k = key_pool[0];
        send_word(make_word(aktt_pkg::OP_QUERY, '0, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b0));       // not yet held
        send_word(make_word(aktt_pkg::OP_TAG, '0, 15'd7, 1'b1));     // key zero ignored
        send_word(make_word(aktt_pkg::OP_TAG, k, 15'd7, 1'b0));      // dead object ignored
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_TAG, k, 15'h7fff, 1'b1));   // longest duration
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_TAG, k, 15'd5, 1'b1));      // shorter: kept, stored
        send_word(make_word(aktt_pkg::OP_TICK, '1, 15'h7fff, 1'b1));
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_TAG, '1, 15'd1, 1'b1));     // all-ones key, one frame
        send_word(make_word(aktt_pkg::OP_QUERY, '1, 15'h7fff, 1'b0));
        send_word(make_word(aktt_pkg::OP_TICK, '0, '0, 1'b0));       // frees the all-ones key
        send_word(make_word(aktt_pkg::OP_QUERY, '1, '0, 1'b1));
        send_word(make_word(OP_UNUSED, k, 15'h7fff, 1'b1));
        send_word(make_word(OP_UNUSED, '0, '0, 1'b0));
    endtask

    // Zero duration: stored, invisible to queries, gone after one tick.
    task automatic test_zero_duration();
        logic [aktt_pkg::KEY_IN_W-1:0] k;
        k = key_pool[1];
        send_word(make_word(aktt_pkg::OP_TAG, k, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_TAG, k, '0, 1'b1));         // refresh of a zero timer
        send_word(make_word(aktt_pkg::OP_TICK, '0, '0, 1'b0));
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_TAG, k, 15'd3, 1'b1));      // re-insert into freed slot
        send_word(make_word(aktt_pkg::OP_QUERY, k, '0, 1'b1));
    endtask

    // Fill the free slots with fresh keys, overflow the table, refresh, then age the fresh keys out.
    task automatic test_full_table();
        logic [aktt_pkg::KEY_IN_W-1:0] fresh [SLOTS + 1];
        for (int i = 0; i <= SLOTS; i++) begin
            fresh[i] = {1'b1, 7'h5a, 24'(i)};                       // outside the pool's reach
            send_word(make_word(aktt_pkg::OP_TAG, fresh[i], 15'd2, 1'b1));
        end
        send_word(make_word(aktt_pkg::OP_QUERY, fresh[SLOTS], '0, 1'b1)); // a dropped one
        send_word(make_word(aktt_pkg::OP_TAG, fresh[0], 15'd2, 1'b1));     // refresh when full
        send_word(make_word(aktt_pkg::OP_TICK, '0, '0, 1'b0));
        send_word(make_word(aktt_pkg::OP_QUERY, fresh[0], '0, 1'b1));
        send_word(make_word(aktt_pkg::OP_TICK, '0, '0, 1'b0));
        send_word(make_word(aktt_pkg::OP_QUERY, fresh[0], '0, 1'b1));
    endtask

    // Receiver stops for a long stretch while the sender keeps pushing words,
    // so the result register fills and s_ready must drop.
    task automatic test_backpressure();
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        hold_len       = 400;
        repeat (60) send_word(random_word());
    endtask

    task automatic test_random_mix(input int gap_pct, input int stall_pct, input int count);
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_word(random_word());
    endtask

    initial begin
        for (int i = 0; i < KEY_POOL_SZ; i++) begin
            do key_pool[i] = $urandom; while (key_pool[i] == '0);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_zero_duration();
        test_full_table();
        test_backpressure();
        test_random_mix(0, 0, 460);
        test_random_mix(57, 0, 460);
        test_random_mix(0, 57, 460);
        test_random_mix(14, 14, 460);

        // drain: stop offering, let every expected word come back, then watch for strays
        s_valid        <= 1'b0;
        sink_stall_pct  = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/aktt_pkg.sv
rtl/aktt_mem.sv
rtl/aktt_seq.sv
rtl/aging_key_timer_table.sv
tb/sv/testbench.sv
